// ----- src/tfn_pkg.sv -----
// Shared definitions for the triangle face normal block.
// Holds default parameter values, the fixed result width and the flag bundle type.
package tfn_pkg;

    localparam int COORD_BITS_DEF       = 24;
    localparam int NORMAL_FRAC_BITS_DEF = 14;
    localparam int NORMAL_BITS          = 16;

    // Per-item side information that rides along the root pipeline.
    typedef struct packed {
        logic [2:0] neg;
        logic       degen;
    } tfn_flags_t;

endpackage

// ----- src/tfn_if.sv -----
// Channel interfaces for triangle input and normal output.
// Depends on tfn_pkg for default widths.
interface tfn_in_if #(
    parameter int COORD_BITS = tfn_pkg::COORD_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] p1_x;
    logic signed [COORD_BITS-1:0] p1_y;
    logic signed [COORD_BITS-1:0] p1_z;
    logic signed [COORD_BITS-1:0] p2_x;
    logic signed [COORD_BITS-1:0] p2_y;
    logic signed [COORD_BITS-1:0] p2_z;
    logic signed [COORD_BITS-1:0] p3_x;
    logic signed [COORD_BITS-1:0] p3_y;
    logic signed [COORD_BITS-1:0] p3_z;

    modport source (output valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
                    input ready);
    modport sink (input valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
                  output ready);
endinterface

interface tfn_out_if ();
    logic                                      valid;
    logic                                      ready;
    logic signed [tfn_pkg::NORMAL_BITS-1:0]    normal_x;
    logic signed [tfn_pkg::NORMAL_BITS-1:0]    normal_y;
    logic signed [tfn_pkg::NORMAL_BITS-1:0]    normal_z;
    logic                                      degenerate;

    modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
    modport sink (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

// ----- src/tfn_front.sv -----
// Front pipeline: edges, cross product, squared components and squared length.
// Depends on tfn_pkg and tfn_in_if; six register stages with a per-stage ready chain.
module tfn_front #(
    parameter int COORD_BITS = tfn_pkg::COORD_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    tfn_in_if.sink                     tri_in,
    output logic                       dn_valid,
    input  logic                       dn_ready,
    output logic [4*COORD_BITS+3:0]    a2 [3],
    output logic [4*COORD_BITS+5:0]    len2,
    output tfn_pkg::tfn_flags_t        flags
);
    import tfn_pkg::*;

    localparam int E  = COORD_BITS + 1;
    localparam int CW = 2 * E;
    localparam int SW = 2 * CW;
    localparam int LW = SW + 2;

    logic [6:1] v_reg;
    logic [6:1] en;

    logic signed [E-1:0]    u_reg [3];
    logic signed [E-1:0]    w_reg [3];
    logic signed [CW-1:0]   pr_reg [3];
    logic signed [CW-1:0]   qr_reg [3];
    logic [CW-1:0]          mag_reg [3];
    logic [2:0]             neg3_reg, neg4_reg, neg5_reg, neg6_reg;
    logic                   dg3_reg, dg4_reg, dg5_reg, dg6_reg;
    logic [CW-1:0]          hh_reg [3];
    logic [CW-1:0]          hl_reg [3];
    logic [CW-1:0]          ll_reg [3];
    logic [SW-1:0]          sq_reg [3];
    logic [SW-1:0]          a2_reg [3];
    logic [LW-1:0]          len2_reg;

    logic signed [E-1:0]    u_next [3];
    logic signed [E-1:0]    w_next [3];
    logic signed [CW:0]     c_next [3];
    logic [CW-1:0]          mag_next [3];
    logic [SW-1:0]          sq_next [3];
    logic [2:0]             neg_next;

    logic signed [E-1:0]    p1 [3];
    logic signed [E-1:0]    p2 [3];
    logic signed [E-1:0]    p3 [3];

    assign p1[0] = E'(tri_in.p1_x);
    assign p1[1] = E'(tri_in.p1_y);
    assign p1[2] = E'(tri_in.p1_z);
    assign p2[0] = E'(tri_in.p2_x);
    assign p2[1] = E'(tri_in.p2_y);
    assign p2[2] = E'(tri_in.p2_z);
    assign p3[0] = E'(tri_in.p3_x);
    assign p3[1] = E'(tri_in.p3_y);
    assign p3[2] = E'(tri_in.p3_z);

    // A stage loads when it is empty or its content moves on in the same cycle.
    always_comb
    begin
        en[6] = !v_reg[6] || dn_ready;
        for (int k = 5; k >= 1; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign tri_in.ready = en[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                v_reg[1] <= tri_in.valid;
            end
            for (int k = 2; k <= 6; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            u_next[i]   = p2[i] - p1[i];
            w_next[i]   = p3[i] - p1[i];
            c_next[i]   = (CW+1)'(pr_reg[i]) - (CW+1)'(qr_reg[i]);
            neg_next[i] = c_next[i][CW];
            mag_next[i] = neg_next[i] ? CW'(-c_next[i]) : CW'(c_next[i]);
            sq_next[i]  = (SW'(hh_reg[i]) << CW) + (SW'(hl_reg[i]) << (E + 1))
                        + SW'(ll_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            u_reg <= u_next;
            w_reg <= w_next;
        end
        if (en[2])
        begin
            for (int i = 0; i < 3; i++)
            begin
                pr_reg[i] <= u_reg[(i+1)%3] * w_reg[(i+2)%3];
                qr_reg[i] <= u_reg[(i+2)%3] * w_reg[(i+1)%3];
            end
        end
        if (en[3])
        begin
            mag_reg  <= mag_next;
            neg3_reg <= neg_next;
            dg3_reg  <= (c_next[0] == '0) && (c_next[1] == '0) && (c_next[2] == '0);
        end
        if (en[4])
        begin
            for (int i = 0; i < 3; i++)
            begin
                hh_reg[i] <= CW'(mag_reg[i][CW-1:E]) * CW'(mag_reg[i][CW-1:E]);
                hl_reg[i] <= CW'(mag_reg[i][CW-1:E]) * CW'(mag_reg[i][E-1:0]);
                ll_reg[i] <= CW'(mag_reg[i][E-1:0]) * CW'(mag_reg[i][E-1:0]);
            end
            neg4_reg <= neg3_reg;
            dg4_reg  <= dg3_reg;
        end
        if (en[5])
        begin
            sq_reg   <= sq_next;
            neg5_reg <= neg4_reg;
            dg5_reg  <= dg4_reg;
        end
        if (en[6])
        begin
            a2_reg   <= sq_reg;
            len2_reg <= LW'(sq_reg[0]) + LW'(sq_reg[1]) + LW'(sq_reg[2]);
            neg6_reg <= neg5_reg;
            dg6_reg  <= dg5_reg;
        end
    end

    assign dn_valid    = v_reg[6];
    assign a2          = a2_reg;
    assign len2        = len2_reg;
    assign flags.neg   = neg6_reg;
    assign flags.degen = dg6_reg;

endmodule

// ----- src/tfn_root_step.sv -----
// One step of the restoring square-root-of-quotient recurrence for three components.
// Depends on tfn_pkg; decides result bit BIT with one shift-add, compare and subtract.
module tfn_root_step #(
    parameter int COORD_BITS       = tfn_pkg::COORD_BITS_DEF,
    parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF,
    parameter int BIT              = 0
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              up_valid,
    output logic                                              up_ready,
    input  logic [4*COORD_BITS+2*NORMAL_FRAC_BITS+10:0]       rem_in [3],
    input  logic [4*COORD_BITS+2*NORMAL_FRAC_BITS+10:0]       p_in [3],
    input  logic [NORMAL_FRAC_BITS+1:0]                       y_in [3],
    input  logic [4*COORD_BITS+5:0]                           len2_in,
    input  tfn_pkg::tfn_flags_t                               flags_in,
    output logic                                              dn_valid,
    input  logic                                              dn_ready,
    output logic [4*COORD_BITS+2*NORMAL_FRAC_BITS+10:0]       rem_out [3],
    output logic [4*COORD_BITS+2*NORMAL_FRAC_BITS+10:0]       p_out [3],
    output logic [NORMAL_FRAC_BITS+1:0]                       y_out [3],
    output logic [4*COORD_BITS+5:0]                           len2_out,
    output tfn_pkg::tfn_flags_t                               flags_out
);
    import tfn_pkg::*;

    localparam int LW = 4 * COORD_BITS + 6;
    localparam int DW = LW + 2 * NORMAL_FRAC_BITS + 5;
    localparam int YW = NORMAL_FRAC_BITS + 2;

    logic              v_reg;
    logic              en;
    logic [DW-1:0]     rem_reg [3];
    logic [DW-1:0]     p_reg [3];
    logic [YW-1:0]     y_reg [3];
    logic [LW-1:0]     len2_reg;
    tfn_flags_t        flags_reg;

    logic [DW-1:0]     d [3];
    logic [DW-1:0]     rem_next [3];
    logic [DW-1:0]     p_next [3];
    logic [YW-1:0]     y_next [3];

    // Trying bit BIT of y: (y + 2^BIT)^2 * len2 - y^2 * len2 = 2^(BIT+1)*P + 4^BIT*len2,
    // where P = y * len2 is kept up to date alongside the remainder.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d[i]        = (p_in[i] << (BIT + 1)) + (DW'(len2_in) << (2 * BIT));
            rem_next[i] = rem_in[i];
            p_next[i]   = p_in[i];
            y_next[i]   = y_in[i];
            if (d[i] <= rem_in[i])
            begin
                rem_next[i] = rem_in[i] - d[i];
                p_next[i]   = p_in[i] + (DW'(len2_in) << BIT);
                y_next[i][BIT] = 1'b1;
            end
        end
    end

    assign en       = !v_reg || dn_ready;
    assign up_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg   <= rem_next;
            p_reg     <= p_next;
            y_reg     <= y_next;
            len2_reg  <= len2_in;
            flags_reg <= flags_in;
        end
    end

    assign dn_valid  = v_reg;
    assign rem_out   = rem_reg;
    assign p_out     = p_reg;
    assign y_out     = y_reg;
    assign len2_out  = len2_reg;
    assign flags_out = flags_reg;

endmodule

// ----- src/tfn_out.sv -----
// Output stage: rounds the root to the nearest step, applies signs, zeroes degenerate results and holds the result.
// Depends on tfn_pkg and tfn_out_if.
module tfn_out #(
    parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          up_valid,
    output logic                          up_ready,
    input  logic [NORMAL_FRAC_BITS+1:0]   y_in [3],
    input  tfn_pkg::tfn_flags_t           flags_in,
    tfn_out_if.source                     norm_out
);
    import tfn_pkg::*;

    localparam int YW = NORMAL_FRAC_BITS + 2;
    localparam int MW = YW + 1;
    localparam int OW = NORMAL_FRAC_BITS + 18;

    logic                   v_reg;
    logic                   en;
    logic [MW-1:0]          m [3];
    logic [OW-1:0]          sv [3];
    logic [NORMAL_BITS-1:0] n_next [3];
    logic [NORMAL_BITS-1:0] nx_reg, ny_reg, nz_reg;
    logic                   dg_reg;

    // y = floor(2 * scaled value); the rounded magnitude is floor((y + 1) / 2).
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            m[i]      = (MW'(y_in[i]) + MW'(1)) >> 1;
            sv[i]     = flags_in.neg[i] ? (OW'(0) - OW'(m[i])) : OW'(m[i]);
            n_next[i] = flags_in.degen ? '0 : sv[i][NORMAL_BITS-1:0];
        end
    end

    assign en       = !v_reg || norm_out.ready;
    assign up_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg <= n_next[0];
            ny_reg <= n_next[1];
            nz_reg <= n_next[2];
            dg_reg <= flags_in.degen;
        end
    end

    assign norm_out.valid      = v_reg;
    assign norm_out.normal_x   = nx_reg;
    assign norm_out.normal_y   = ny_reg;
    assign norm_out.normal_z   = nz_reg;
    assign norm_out.degenerate = dg_reg;

endmodule

// ----- src/triangle_face_normal.sv -----
// Triangle unit face normal: a fully pipelined unit that takes one triangle per cycle
// while not back-pressured and returns each cross-product component scaled to unit
// length in signed Q1.14, rounded to nearest with ties away from zero, exact in integer
// arithmetic. The pipeline is six front stages for edges, cross product and squared
// length, one stage per result bit of the square-root recurrence, and the output
// register. A zero cross product gives a zero normal and degenerate = 1.
// Backpressure stalls stage by stage, so bubbles are squeezed out.
module triangle_face_normal #(
    parameter int COORD_BITS       = tfn_pkg::COORD_BITS_DEF,
    parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    tfn_in_if.sink     tri_in,
    tfn_out_if.source  norm_out
);
    import tfn_pkg::*;

    localparam int SW = 4 * COORD_BITS + 4;
    localparam int LW = SW + 2;
    localparam int DW = LW + 2 * NORMAL_FRAC_BITS + 5;
    localparam int YW = NORMAL_FRAC_BITS + 2;
    localparam int NS = NORMAL_FRAC_BITS + 2;
    localparam int LIM = 1 << NORMAL_FRAC_BITS;

    logic [SW-1:0]  f_a2 [3];
    logic [LW-1:0]  f_len2;
    tfn_flags_t     f_flags;

    logic           st_valid [NS+1];
    logic           st_ready [NS+1];
    logic [DW-1:0]  rem_w [NS+1][3];
    logic [DW-1:0]  p_w [NS+1][3];
    logic [YW-1:0]  y_w [NS+1][3];
    logic [LW-1:0]  len2_w [NS+1];
    tfn_flags_t     flags_w [NS+1];

    tfn_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .tri_in   (tri_in),
        .dn_valid (st_valid[0]),
        .dn_ready (st_ready[0]),
        .a2       (f_a2),
        .len2     (f_len2),
        .flags    (f_flags)
    );

    // The recurrence starts from remainder 4^(F+1) * c_i^2 with an empty root.
    for (genvar i = 0; i < 3; i++)
    begin : g_seed
        assign rem_w[0][i] = DW'(f_a2[i]) << (2 * (NORMAL_FRAC_BITS + 1));
        assign p_w[0][i]   = '0;
        assign y_w[0][i]   = '0;
    end
    assign len2_w[0]  = f_len2;
    assign flags_w[0] = f_flags;

    for (genvar k = 0; k < NS; k++)
    begin : g_root
        tfn_root_step #(
            .COORD_BITS       (COORD_BITS),
            .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS),
            .BIT              (NS - 1 - k)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .up_valid  (st_valid[k]),
            .up_ready  (st_ready[k]),
            .rem_in    (rem_w[k]),
            .p_in      (p_w[k]),
            .y_in      (y_w[k]),
            .len2_in   (len2_w[k]),
            .flags_in  (flags_w[k]),
            .dn_valid  (st_valid[k+1]),
            .dn_ready  (st_ready[k+1]),
            .rem_out   (rem_w[k+1]),
            .p_out     (p_w[k+1]),
            .y_out     (y_w[k+1]),
            .len2_out  (len2_w[k+1]),
            .flags_out (flags_w[k+1])
        );
    end

    tfn_out #(
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (st_valid[NS]),
        .up_ready (st_ready[NS]),
        .y_in     (y_w[NS]),
        .flags_in (flags_w[NS]),
        .norm_out (norm_out)
    );

`ifndef SYNTHESIS
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        norm_out.valid && norm_out.degenerate |->
            norm_out.normal_x == '0 && norm_out.normal_y == '0 && norm_out.normal_z == '0)
        else $error("degenerate result with nonzero normal");

    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !norm_out.valid |-> tri_in.ready)
        else $error("input stalled while output register is empty");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        norm_out.valid && (NORMAL_FRAC_BITS <= 14) |->
            $signed(norm_out.normal_x) <= LIM && $signed(norm_out.normal_x) >= -LIM &&
            $signed(norm_out.normal_y) <= LIM && $signed(norm_out.normal_y) >= -LIM &&
            $signed(norm_out.normal_z) <= LIM && $signed(norm_out.normal_z) >= -LIM)
        else $error("normal component exceeds unit length");
`endif

endmodule
